// File: design/cfpf_pkg.sv
package cfpf_pkg;

  // Operand width of the phase, the configuration registers and the period.
  localparam int unsigned WIDTH     = 16;
  // Width of a full product, which is also the dividend width of the divider.
  localparam int unsigned PROD_W    = 2 * WIDTH;
  // Divider step counter width.
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W);
  // Configuration register index width.
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DENOMINATOR = CFG_IDX_W'(2);

  // Configuration reset values.
  localparam logic [WIDTH-1:0] MODULUS_RST     = WIDTH'(15);
  localparam logic [WIDTH-1:0] BASE_RST        = WIDTH'(7);
  localparam logic [WIDTH-1:0] DENOMINATOR_RST = WIDTH'(16);

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_TEST,
    S_BRED,
    S_EXP,
    S_MODA,
    S_WA,
    S_SQ,
    S_MODS,
    S_WS,
    S_CHECK,
    S_NEXT,
    S_WE
  } state_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_TERM,
    OP_UPD_R,
    OP_EXP_INIT,
    OP_MUL_ACC,
    OP_MUL_SQ,
    OP_DIV_PROD,
    OP_TAKE_ACC,
    OP_TAKE_SQ,
    OP_TAKE_BASE,
    OP_DIV_EUCLID,
    OP_TAKE_TERM,
    OP_REPORT_FOUND,
    OP_REPORT_NONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic den_zero;
    logic r_testable;
    logic e_zero;
    logic e_lsb;
    logic acc_is_nm1;
  } status_t;

endpackage

// File: design/cfpf_div.sv
module cfpf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cfpf_pkg::PROD_W-1:0] dividend_i,
  input  logic [cfpf_pkg::WIDTH-1:0]  divisor_i,
  output logic                       done_o,
  output logic [cfpf_pkg::WIDTH-1:0]  quot_o,
  output logic [cfpf_pkg::WIDTH-1:0]  rem_o
);
  import cfpf_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0]     rem_q, rem_d;
  logic [PROD_W-1:0]    quo_q, quo_d;
  logic [WIDTH-1:0]     dvs_q, dvs_d;
  logic [WIDTH:0]       shifted;
  logic [WIDTH:0]       diff;

  // One restoring step per cycle, one quotient bit at a time.
  always_comb begin
    shifted = {rem_q, quo_q[PROD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(PROD_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
        quo_d = {quo_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[WIDTH-1:0];
        quo_d = {quo_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working operands.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[WIDTH-1:0];
  assign rem_o  = rem_q;

endmodule

// File: design/cfpf_datapath.sv
module cfpf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfpf_pkg::cmd_t                cmd_i,
  output cfpf_pkg::status_t             status_o,
  input  logic [cfpf_pkg::WIDTH-1:0]     phase_i,
  input  logic                          cfg_we_i,
  input  logic [cfpf_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [cfpf_pkg::WIDTH-1:0]     cfg_wdata_i,
  output logic                          found_o,
  output logic [cfpf_pkg::WIDTH-1:0]     period_o
);
  import cfpf_pkg::*;

  logic [WIDTH-1:0]  modulus_q, base_q, denom_q;
  logic [WIDTH-1:0]  num_q, den_q, term_q, prev_q, pprev_q, r_q;
  logic [WIDTH-1:0]  e_q, acc_q, sq_q;
  logic [PROD_W-1:0] prod_q;
  logic              found_q;
  logic [WIDTH-1:0]  period_q;

  logic [WIDTH-1:0]  mul_a, mul_b;
  logic              div_start;
  logic [PROD_W-1:0] div_dividend;
  logic [WIDTH-1:0]  div_divisor;
  logic              div_done;
  logic [WIDTH-1:0]  div_quot, div_rem;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      base_q    <= BASE_RST;
      denom_q   <= DENOMINATOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MODULUS:     modulus_q <= cfg_wdata_i;
        CFG_BASE:        base_q    <= cfg_wdata_i;
        CFG_DENOMINATOR: denom_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd_i.op)
      OP_MUL_TERM: begin
        mul_a = term_q;
        mul_b = prev_q;
      end
      OP_MUL_ACC: begin
        mul_a = acc_q;
        mul_b = sq_q;
      end
      default: begin
        mul_a = sq_q;
        mul_b = sq_q;
      end
    endcase
  end

  // Divider operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = modulus_q;
    case (cmd_i.op)
      OP_EXP_INIT: begin
        div_start    = 1'b1;
        div_dividend = PROD_W'(base_q);
      end
      OP_DIV_PROD: begin
        div_start = 1'b1;
      end
      OP_DIV_EUCLID: begin
        div_start    = 1'b1;
        div_dividend = PROD_W'(num_q);
        div_divisor  = den_q;
      end
      default: ;
    endcase
  end

  cfpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Working registers, updated by the current operation.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        num_q   <= denom_q;
        den_q   <= phase_i;
        term_q  <= '0;
        prev_q  <= '0;
        pprev_q <= WIDTH'(1);
      end
      OP_MUL_TERM, OP_MUL_ACC, OP_MUL_SQ: begin
        prod_q <= mul_a * mul_b;
      end
      OP_UPD_R: begin
        r_q     <= prod_q[WIDTH-1:0] + pprev_q;
        prev_q  <= prod_q[WIDTH-1:0] + pprev_q;
        pprev_q <= prev_q;
      end
      OP_EXP_INIT: begin
        e_q   <= r_q >> 1;
        acc_q <= (modulus_q == WIDTH'(1)) ? '0 : WIDTH'(1);
      end
      OP_TAKE_ACC: begin
        acc_q <= div_rem;
      end
      OP_TAKE_SQ: begin
        sq_q <= div_rem;
        e_q  <= e_q >> 1;
      end
      // The base reduction lands in the squaring register and leaves the
      // exponent alone.
      OP_TAKE_BASE: begin
        sq_q <= div_rem;
      end
      OP_TAKE_TERM: begin
        term_q <= div_quot;
        num_q  <= den_q;
        den_q  <= div_rem;
      end
      default: ;
    endcase
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_REPORT_FOUND) begin
      found_q  <= 1'b1;
      period_q <= r_q;
    end else if (cmd_i.op == OP_REPORT_NONE) begin
      found_q  <= 1'b0;
      period_q <= '0;
    end
  end

  assign status_o.div_done   = div_done;
  assign status_o.den_zero   = (den_q == '0);
  assign status_o.r_testable = !r_q[0] && (modulus_q != '0);
  assign status_o.e_zero     = (e_q == '0);
  assign status_o.e_lsb      = e_q[0];
  assign status_o.acc_is_nm1 = (acc_q == modulus_q - WIDTH'(1));

  assign found_o  = found_q;
  assign period_o = period_q;

endmodule

// File: design/cfpf_ctrl.sv
module cfpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cfpf_pkg::status_t status_i,
  output cfpf_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import cfpf_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_MUL;
      S_MUL:   state_d = S_UPD;
      S_UPD:   state_d = S_TEST;
      S_TEST:  state_d = status_i.r_testable ? S_BRED : S_NEXT;
      S_BRED:  if (status_i.div_done) state_d = S_EXP;
      S_EXP: begin
        if (status_i.e_zero) begin
          state_d = S_CHECK;
        end else if (status_i.e_lsb) begin
          state_d = S_MODA;
        end else begin
          state_d = S_MODS;
        end
      end
      S_MODA:  state_d = S_WA;
      S_WA:    if (status_i.div_done) state_d = S_SQ;
      S_SQ:    state_d = S_MODS;
      S_MODS:  state_d = S_WS;
      S_WS:    if (status_i.div_done) state_d = S_EXP;
      S_CHECK: state_d = status_i.acc_is_nm1 ? S_NEXT : S_IDLE;
      S_NEXT:  state_d = status_i.den_zero ? S_IDLE : S_WE;
      S_WE:    if (status_i.div_done) state_d = S_MUL;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.op = OP_NONE;
    done_d   = 1'b0;
    case (state_q)
      S_IDLE:  if (start_i) cmd_o.op = OP_LOAD;
      S_MUL:   cmd_o.op = OP_MUL_TERM;
      S_UPD:   cmd_o.op = OP_UPD_R;
      S_TEST:  if (status_i.r_testable) cmd_o.op = OP_EXP_INIT;
      S_BRED:  if (status_i.div_done) cmd_o.op = OP_TAKE_BASE;
      S_EXP: begin
        if (!status_i.e_zero) begin
          cmd_o.op = status_i.e_lsb ? OP_MUL_ACC : OP_MUL_SQ;
        end
      end
      S_MODA:  cmd_o.op = OP_DIV_PROD;
      S_WA:    if (status_i.div_done) cmd_o.op = OP_TAKE_ACC;
      S_SQ:    cmd_o.op = OP_MUL_SQ;
      S_MODS:  cmd_o.op = OP_DIV_PROD;
      S_WS:    if (status_i.div_done) cmd_o.op = OP_TAKE_SQ;
      S_CHECK: begin
        if (!status_i.acc_is_nm1) begin
          cmd_o.op = OP_REPORT_FOUND;
          done_d   = 1'b1;
        end
      end
      S_NEXT: begin
        if (status_i.den_zero) begin
          cmd_o.op = OP_REPORT_NONE;
          done_d   = 1'b1;
        end else begin
          cmd_o.op = OP_DIV_EUCLID;
        end
      end
      S_WE:    if (status_i.div_done) cmd_o.op = OP_TAKE_TERM;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: design/continued_fraction_period_finder_top.sv
// Continued-fraction period finder. Pulse start_i while busy_o is low to hand
// in one phase; exactly one result beat follows, shown on found_o and period_o
// for the single cycle in which done_o is high, and it cannot be held off.
// The block works on one phase at a time. Each continued-fraction term takes
// one division on the shared 32-step serial divider; each even convergent
// (with a nonzero modulus) adds a base reduction and, per exponent bit,
// one or two multiply-and-reduce passes through that divider. Configuration
// must be written only while busy_o is low; the block does not enforce it.
module continued_fraction_period_finder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [cfpf_pkg::WIDTH-1:0]     phase_i,
  input  logic                          cfg_we_i,
  input  logic [cfpf_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [cfpf_pkg::WIDTH-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [cfpf_pkg::WIDTH-1:0]     period_o
);
  import cfpf_pkg::*;

  cmd_t    cmd;
  status_t status;

  cfpf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  cfpf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .phase_i     (phase_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .found_o     (found_o),
    .period_o    (period_o)
  );

endmodule

// File: design/cfpf_checker.sv
module cfpf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic                      found_o,
  input logic [cfpf_pkg::WIDTH-1:0] period_o
);

  // A result beat is only shown once the block has gone idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result beat while busy");

  // Every finished phase ends with a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result beat");

  // An accepted phase makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted phase did not start work");

  // A reported period is even, and zero when nothing was found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !period_o[0] && (found_o || period_o == '0))
    else $error("bad period in result beat");

endmodule

bind continued_fraction_period_finder_top cfpf_checker u_cfpf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .found_o  (found_o),
  .period_o (period_o)
);

// File: dv/continued_fraction_period_finder_top_tb.sv
module continued_fraction_period_finder_top_tb;
  import cfpf_pkg::*;

  localparam longint unsigned CycleLimit = 64'd12_000_000;

  typedef struct {
    logic                found;
    logic [WIDTH-1:0]    period;
  } outcome_t;

  // One row of the directed part: either a register write or a phase beat.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [WIDTH-1:0]     value;
    bit                   typed;
    logic                 found;
    logic [WIDTH-1:0]     period;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [WIDTH-1:0]     phase_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [WIDTH-1:0]     cfg_wdata_i;
  logic                 done_o;
  logic                 found_o;
  logic [WIDTH-1:0]     period_o;

  // Local copy of the configuration registers.
  logic [WIDTH-1:0] n_reg;
  logic [WIDTH-1:0] a_reg;
  logic [WIDTH-1:0] m_reg;

  outcome_t        pending_periods[$];
  int              fail_count;
  int              sender_idle_pct;
  longint unsigned cycle_count;

  continued_fraction_period_finder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .phase_i    (phase_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .found_o    (found_o),
    .period_o   (period_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Exact b^e mod n.
  function automatic longint unsigned mod_power(longint unsigned b, longint unsigned e,
                                                longint unsigned n);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1 % n;
    sq  = b % n;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % n;
      sq = (sq * sq) % n;
      e  = e >> 1;
    end
    return acc;
  endfunction

  // Walks the convergent denominators of phase/m and returns the first even one
  // whose half power of the base is not n-1.
  function automatic outcome_t find_period(logic [WIDTH-1:0] phase);
    longint unsigned quot[96];
    int              nterms;
    longint unsigned num;
    longint unsigned den;
    longint unsigned rem;
    longint unsigned prev;
    longint unsigned prevprev;
    longint unsigned r;
    outcome_t        res;
    nterms   = 1;
    quot[0]  = 0;
    num      = m_reg;
    den      = phase;
    prev     = 0;
    prevprev = 1;
    while (den != 0 && nterms < 96) begin
      rem          = num % den;
      quot[nterms] = num / den;
      nterms++;
      num = den;
      den = rem;
    end
    res.found  = 1'b0;
    res.period = '0;
    for (int i = 0; i < nterms; i++) begin
      r        = quot[i] * prev + prevprev;
      prevprev = prev;
      prev     = r;
      if (!r[0] && n_reg != 0 && mod_power(a_reg, r >> 1, n_reg) != n_reg - 1) begin
        res.found  = 1'b1;
        res.period = r[WIDTH-1:0];
        return res;
      end
    end
    return res;
  endfunction

  // Result beats are compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_periods.size() == 0) begin
        $error("result beat with nothing expected: found=%0d period=%0d",
               found_o, period_o);
        fail_count++;
      end else begin
        if (found_o !== pending_periods[0].found) begin
          $error("found: expected %0d, actual %0d", pending_periods[0].found, found_o);
          fail_count++;
        end
        if (period_o !== pending_periods[0].period) begin
          $error("period: expected %0d, actual %0d", pending_periods[0].period, period_o);
          fail_count++;
        end
        void'(pending_periods.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** continued_fraction_period_finder_top: FAILED **");
      $finish;
    end
  end

  // Hands in one phase; start stays high afterward so back-to-back beats need
  // no extra edge on it.
  task automatic send_phase(logic [WIDTH-1:0] phase, bit typed, outcome_t typed_res);
    int gap;
    outcome_t res;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    phase_i <= phase;
    do @(posedge clk_i); while (busy_o);
    res = find_period(phase);
    if (typed && (res.found !== typed_res.found || res.period !== typed_res.period)) begin
      $error("directed row disagrees with predictor for phase %0d", phase);
      fail_count++;
    end
    if (typed) res = typed_res;
    pending_periods.insert(pending_periods.size(), res);
  endtask

  // Waits until every expected beat is in and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_periods.size() != 0 || busy_o);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_MODULUS:     n_reg = value;
      CFG_BASE:        a_reg = value;
      CFG_DENOMINATOR: m_reg = value;
      default: ;
    endcase
  endtask

  function automatic logic [WIDTH-1:0] pick_reg(logic [WIDTH-1:0] lo);
    case ($urandom_range(5))
      0:       return lo;
      1:       return 16'hFFFF;
      2:       return WIDTH'($urandom_range(lo, 64));
      default: return WIDTH'($urandom_range(lo, 16'hFFFF));
    endcase
  endfunction

  row_t     rows[$];
  outcome_t exp_res;
  logic [WIDTH-1:0] ph;

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    phase_i         = '0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_MODULUS;
    cfg_wdata_i     = '0;
    fail_count      = 0;
    cycle_count     = 0;
    sender_idle_pct = 14;
    n_reg           = MODULUS_RST;
    a_reg           = BASE_RST;
    m_reg           = DENOMINATOR_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset settings, then the register extremes.
    rows = '{
      '{0, CFG_MODULUS, 16'd0,     1, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd16,    1, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'hFFFF,  1, 1'b1, 16'd0},
      '{0, CFG_MODULUS, 16'd8,     1, 1'b1, 16'd2},
      '{0, CFG_MODULUS, 16'd3,     0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd5,     0, 1'b0, 16'd0},
      '{1, CFG_MODULUS, 16'd0,     0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd16,    1, 1'b0, 16'd0},
      '{1, CFG_MODULUS, 16'd1,     0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd16,    1, 1'b0, 16'd0},
      '{1, CFG_MODULUS, 16'hFFFF,  0, 1'b0, 16'd0},
      '{1, CFG_BASE,    16'hFFFF,  0, 1'b0, 16'd0},
      '{1, CFG_DENOMINATOR, 16'hFFFF, 0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd1,     0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'h5555,  0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'hAAAA,  0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'hFFFE,  0, 1'b0, 16'd0},
      '{1, CFG_DENOMINATOR, 16'd0, 0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd0,     1, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd77,    0, 1'b0, 16'd0},
      '{1, CFG_MODULUS, 16'd3,     0, 1'b0, 16'd0},
      '{1, CFG_BASE,    16'd2,     0, 1'b0, 16'd0},
      '{1, CFG_DENOMINATOR, 16'd1, 0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd0,     0, 1'b0, 16'd0},
      '{0, CFG_MODULUS, 16'd1,     0, 1'b0, 16'd0}
    };
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].value);
        cfg_we_i <= 1'b0;
      end else begin
        exp_res.found  = rows[i].found;
        exp_res.period = rows[i].period;
        send_phase(rows[i].value, rows[i].typed, exp_res);
      end
    end

    // Random part: six settings, two per idling pattern, with a full pause
    // before every reconfiguration.
    for (int s = 0; s < 6; s++) begin
      sender_idle_pct = (s < 2) ? 14 : (s < 4) ? 80 : 0;
      drain();
      write_reg(CFG_MODULUS, pick_reg(16'd3));
      write_reg(CFG_BASE, pick_reg(16'd2));
      write_reg(CFG_DENOMINATOR, pick_reg(16'd1));
      cfg_we_i <= 1'b0;
      for (int k = 0; k < 47; k++) begin
        case ($urandom_range(9))
          0:       ph = '0;
          1:       ph = WIDTH'($urandom_range(16'hFFFF));
          2:       ph = m_reg;
          default: ph = WIDTH'($urandom_range(m_reg));
        endcase
        send_phase(ph, 1'b0, exp_res);
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** continued_fraction_period_finder_top: PASSED **");
    end else begin
      $display("** continued_fraction_period_finder_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/cfpf_pkg.sv
design/cfpf_div.sv
design/cfpf_datapath.sv
design/cfpf_ctrl.sv
design/continued_fraction_period_finder_top.sv
design/cfpf_checker.sv
dv/continued_fraction_period_finder_top_tb.sv
